### rtl/core/mnva_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mnva_pkg;

  localparam int VOICE_COUNT = 12;
  localparam int VIDX_W      = 4;
  localparam int NOTE_W      = 7;

  localparam logic [7:0] MIDI_CLOCK   = 8'hF8;
  localparam logic [7:0] ACTIVE_SENSE = 8'hFE;
  localparam logic [3:0] CMD_NOTE_OFF = 4'h8;
  localparam logic [3:0] CMD_NOTE_ON  = 4'h9;
  localparam logic [NOTE_W-1:0] NOTE_LOW  = 7'd21;
  localparam logic [NOTE_W-1:0] NOTE_HIGH = 7'd108;

  localparam logic OP_MIDI_BYTE = 1'b0;
  localparam logic OP_SILENT    = 1'b1;

  localparam logic ACT_START   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    MODE_SILENT    = 2'd0,
    MODE_HELD      = 2'd1,
    MODE_RELEASING = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_DONE = 2'd2
  } state_t;

  // Search token that walks the row of voices, one voice per cycle.
  typedef struct packed {
    logic              valid;
    logic              note_off;
    logic [NOTE_W-1:0] note;
    logic              free_hit;
    logic [VIDX_W-1:0] free_idx;
    logic              rel_hit;
    logic [VIDX_W-1:0] rel_idx;
    logic              match_hit;
    logic [VIDX_W-1:0] match_idx;
  } query_t;

  // Direct write to one voice from the controller.
  typedef struct packed {
    logic              clr;
    logic              set;
    logic [VIDX_W-1:0] idx;
    logic [NOTE_W-1:0] note;
  } voice_cmd_t;

endpackage

`default_nettype wire

### rtl/core/mnva_voice_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module mnva_voice_cell (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [mnva_pkg::VIDX_W-1:0] cell_idx,
  input  wire mnva_pkg::voice_cmd_t       cmd,
  input  wire mnva_pkg::query_t           q_in,
  output mnva_pkg::query_t                q_out
);

  mnva_pkg::mode_t                mode;
  mnva_pkg::mode_t                mode_next;
  logic [mnva_pkg::NOTE_W-1:0]    note;
  logic [mnva_pkg::NOTE_W-1:0]    note_next;
  mnva_pkg::query_t               q_next;
  logic                           hit_release;
  logic                           cmd_here;

  assign cmd_here    = (cmd.idx == cell_idx);
  assign hit_release = q_in.valid && q_in.note_off && !q_in.match_hit &&
                       (mode == mnva_pkg::MODE_HELD) && (note == q_in.note);

  always_comb begin
    q_next = q_in;
    if (q_in.valid && !q_in.note_off) begin
      if (mode == mnva_pkg::MODE_SILENT && !q_in.free_hit) begin
        q_next.free_hit = 1'b1;
        q_next.free_idx = cell_idx;
      end
      if (mode == mnva_pkg::MODE_RELEASING && !q_in.rel_hit) begin
        q_next.rel_hit = 1'b1;
        q_next.rel_idx = cell_idx;
      end
    end
    if (hit_release) begin
      q_next.match_hit = 1'b1;
      q_next.match_idx = cell_idx;
    end
  end

  always_comb begin
    mode_next = mode;
    note_next = note;
    if (cmd.clr && cmd_here) begin
      mode_next = mnva_pkg::MODE_SILENT;
      note_next = '0;
    end else if (cmd.set && cmd_here) begin
      mode_next = mnva_pkg::MODE_HELD;
      note_next = cmd.note;
    end else if (hit_release) begin
      mode_next = mnva_pkg::MODE_RELEASING;
      note_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= mnva_pkg::MODE_SILENT;
      note  <= '0;
      q_out <= '0;
    end else begin
      mode  <= mode_next;
      note  <= note_next;
      q_out <= q_next;
    end
  end

  // A start never lands on a voice that is still held.
  assert property (@(posedge clk) disable iff (rst)
    (cmd.set && cmd_here) |-> (mode != mnva_pkg::MODE_HELD))
    else $error("start written over a held voice");

  // A claimed release is never lost on its way down the row.
  assert property (@(posedge clk) disable iff (rst)
    (q_in.valid && q_in.match_hit) |=> (q_out.valid && q_out.match_hit))
    else $error("release match dropped in cell");

  // A release hit on a held voice moves that voice to releasing.
  assert property (@(posedge clk) disable iff (rst)
    hit_release |=> (mode == mnva_pkg::MODE_RELEASING))
    else $error("release hit did not update voice");

endmodule

`default_nettype wire

### rtl/core/midi_note_voice_allocator.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel | Handshake            | Payload
// --------+----------------------+---------------------------------------------
// in      | in_valid / in_ready  | op, midi_byte, silent_voice
// out     | out_valid / out_ready| action, voice_index, note_number, key_velocity
//
// Bytes, silent reports and messages that need no voice are taken while idle and leave it idle.
// A completed note-off, or note-on in the playable range, walks a search token
// down the row of voice cells, one voice per cycle, with no input taken meanwhile.
// The result sits in an output register; new transactions are taken while it
// waits, but a later result stalls in the done state until it is taken.
// Synchronous reset clears the parser, all voices to silent, and out_valid.

module midi_note_voice_allocator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        op,
  input  wire logic [7:0]  midi_byte,
  input  wire logic [3:0]  silent_voice,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             action,
  output logic [3:0]       voice_index,
  output logic [6:0]       note_number,
  output logic [6:0]       key_velocity
);

  localparam int VC = mnva_pkg::VOICE_COUNT;

  mnva_pkg::state_t            state;
  mnva_pkg::state_t            state_next;
  logic [7:0]                  running_status;
  logic                        data_count;
  logic [mnva_pkg::NOTE_W-1:0] first_data_byte;
  logic [mnva_pkg::NOTE_W-1:0] vel;
  mnva_pkg::query_t            chain [0:VC];
  mnva_pkg::query_t            q_launch;
  mnva_pkg::query_t            res;
  mnva_pkg::voice_cmd_t        cmd;
  logic [VC:0]                 qvec;

  logic                        accept;
  logic                        is_byte;
  logic                        is_status;
  logic                        pair_done;
  logic [3:0]                  cmd_nib;
  logic [mnva_pkg::NOTE_W-1:0] byte_low;
  logic                        want_release;
  logic                        want_start;
  logic                        launch;
  logic                        out_free;
  logic                        has_result;
  logic                        load_out;
  logic [mnva_pkg::VIDX_W-1:0] pick_idx;

  assign accept    = in_valid && in_ready;
  assign byte_low  = midi_byte[6:0];
  assign is_byte   = (op == mnva_pkg::OP_MIDI_BYTE) && (midi_byte != mnva_pkg::MIDI_CLOCK) &&
                     (midi_byte != mnva_pkg::ACTIVE_SENSE);
  assign is_status = is_byte && midi_byte[7];
  assign pair_done = is_byte && !midi_byte[7] && data_count;
  assign cmd_nib   = running_status[7:4];

  assign want_release = (cmd_nib == mnva_pkg::CMD_NOTE_OFF) ||
                        ((cmd_nib == mnva_pkg::CMD_NOTE_ON) && (byte_low == '0));
  assign want_start   = (cmd_nib == mnva_pkg::CMD_NOTE_ON) && (byte_low != '0) &&
                        (first_data_byte >= mnva_pkg::NOTE_LOW) &&
                        (first_data_byte <= mnva_pkg::NOTE_HIGH);
  assign launch       = accept && pair_done && (want_release || want_start);

  assign out_free = !out_valid || out_ready;

  always_comb begin
    q_launch          = '0;
    q_launch.valid    = 1'b1;
    q_launch.note_off = want_release;
    q_launch.note     = first_data_byte;
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      running_status  <= '0;
      data_count      <= 1'b0;
      first_data_byte <= '0;
    end else if (accept) begin
      if (is_status) begin
        running_status <= midi_byte;
        data_count     <= 1'b0;
      end else if (is_byte) begin
        if (!data_count) begin
          first_data_byte <= byte_low;
        end
        data_count <= !data_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (launch) begin
      vel <= byte_low;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0] <= '0;
    end else if (launch) begin
      chain[0] <= q_launch;
    end else begin
      chain[0] <= '0;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < VC; gi++) begin : g_voice
      mnva_voice_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .cell_idx (mnva_pkg::VIDX_W'(gi)),
        .cmd      (cmd),
        .q_in     (chain[gi]),
        .q_out    (chain[gi+1])
      );
    end
    for (gi = 0; gi <= VC; gi++) begin : g_qvec
      assign qvec[gi] = chain[gi].valid;
    end
  endgenerate

  // Hold the finished token for the done state
  always_ff @(posedge clk) begin
    if (chain[VC].valid) begin
      res <= chain[VC];
    end
  end

  always_comb begin
    has_result = 1'b0;
    pick_idx   = res.match_idx;
    if (res.note_off) begin
      has_result = res.match_hit;
    end else if (res.free_hit) begin
      has_result = 1'b1;
      pick_idx   = res.free_idx;
    end else if (res.rel_hit) begin
      has_result = 1'b1;
      pick_idx   = res.rel_idx;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mnva_pkg::ST_IDLE: if (launch) state_next = mnva_pkg::ST_SCAN;
      mnva_pkg::ST_SCAN: if (chain[VC].valid) state_next = mnva_pkg::ST_DONE;
      mnva_pkg::ST_DONE: if (!has_result || out_free) state_next = mnva_pkg::ST_IDLE;
      default:           state_next = mnva_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    cmd      = '0;
    unique case (state)
      mnva_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.clr  = in_valid && (op == mnva_pkg::OP_SILENT) &&
                   ({1'b0, silent_voice} < 5'(VC));
        cmd.idx  = silent_voice;
      end
      mnva_pkg::ST_DONE: begin
        load_out = has_result && out_free;
        cmd.set  = load_out && !res.note_off;
        cmd.idx  = pick_idx;
        cmd.note = res.note;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mnva_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      action       <= res.note_off ? mnva_pkg::ACT_RELEASE : mnva_pkg::ACT_START;
      voice_index  <= pick_idx;
      note_number  <= res.note;
      key_velocity <= res.note_off ? '0 : vel;
    end
  end

  // Only one search token is ever in the row.
  assert property (@(posedge clk) disable iff (rst) $onehot0(qvec))
    else $error("more than one token in voice row");

  // A token is in flight exactly while scanning.
  assert property (@(posedge clk) disable iff (rst)
    (state == mnva_pkg::ST_SCAN) == (|qvec))
    else $error("scan state and token disagree");

  // A loaded result reaches the output on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    load_out |=> (out_valid && (state == mnva_pkg::ST_IDLE)))
    else $error("result not presented after load");

endmodule

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import mnva_pkg::*;

  typedef struct packed {
    logic              action;
    logic [VIDX_W-1:0] voice;
    logic [NOTE_W-1:0] note;
    logic [6:0]        vel;
  } voice_evt_t;

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_EVENT
  } row_check_t;

  typedef struct packed {
    logic        op;
    logic [7:0]  midi_byte;
    logic [3:0]  silent_voice;
    row_check_t  chk;
    voice_evt_t  evt;
  } stim_row_t;

  localparam voice_evt_t NO_EVT         = '0;
  localparam int         RX_HOLD_CYCLES = 400;
  localparam int         DRAIN_LIMIT    = 20000;
  localparam int         SCRIPT_LEN     = 26;

  localparam stim_row_t SCRIPT [SCRIPT_LEN] = '{
    // pair with no running command
    '{OP_MIDI_BYTE, 8'h3C, 4'd0, CHK_NONE,  NO_EVT},
    '{OP_MIDI_BYTE, 8'h40, 4'd0, CHK_NONE,  NO_EVT},
    '{OP_MIDI_BYTE, 8'h90, 4'd0, CHK_NONE,  NO_EVT},
    // lowest and highest playable notes, max and min velocity
    '{OP_MIDI_BYTE, 8'h15, 4'd0, CHK_NONE,  NO_EVT},
    '{OP_MIDI_BYTE, 8'h7F, 4'd0, CHK_EVENT, '{ACT_START, 4'd0, 7'd21, 7'd127}},
    '{OP_MIDI_BYTE, 8'h6C, 4'd0, CHK_NONE,  NO_EVT},
    '{OP_MIDI_BYTE, 8'h01, 4'd0, CHK_EVENT, '{ACT_START, 4'd1, 7'd108, 7'd1}},
    // just outside the playable range
    '{OP_MIDI_BYTE, 8'h14, 4'd0, CHK_NONE,  NO_EVT},
    '{OP_MIDI_BYTE, 8'h40, 4'd0, CHK_NONE,  NO_EVT},
    '{OP_MIDI_BYTE, 8'h6D, 4'd0, CHK_NONE,  NO_EVT},
    '{OP_MIDI_BYTE, 8'h40, 4'd0, CHK_NONE,  NO_EVT},
    // real-time bytes inside a pair, then note-on with zero velocity
    '{OP_MIDI_BYTE, 8'h15, 4'd0, CHK_NONE,  NO_EVT},
    '{OP_MIDI_BYTE, MIDI_CLOCK, 4'd0, CHK_NONE, NO_EVT},
    '{OP_MIDI_BYTE, ACTIVE_SENSE, 4'd0, CHK_NONE, NO_EVT},
    '{OP_MIDI_BYTE, 8'h00, 4'd0, CHK_EVENT, '{ACT_RELEASE, 4'd0, 7'd21, 7'd0}},
    // note-off
    '{OP_MIDI_BYTE, 8'h80, 4'd0, CHK_NONE,  NO_EVT},
    '{OP_MIDI_BYTE, 8'h6C, 4'd0, CHK_NONE,  NO_EVT},
    '{OP_MIDI_BYTE, 8'h7F, 4'd0, CHK_EVENT, '{ACT_RELEASE, 4'd1, 7'd108, 7'd0}},
    // note-on on the top channel, free slot chosen past the releasing ones
    '{OP_MIDI_BYTE, 8'h9F, 4'd0, CHK_NONE,  NO_EVT},
    '{OP_MIDI_BYTE, 8'h3C, 4'd0, CHK_NONE,  NO_EVT},
    '{OP_MIDI_BYTE, 8'h64, 4'd0, CHK_MODEL, NO_EVT},
    // silent reports, out of range index and a real one
    '{OP_SILENT,    8'hFF, 4'hF, CHK_NONE,  NO_EVT},
    '{OP_SILENT,    8'h00, 4'h0, CHK_NONE,  NO_EVT},
    // control change is ignored
    '{OP_MIDI_BYTE, 8'hB0, 4'd0, CHK_NONE,  NO_EVT},
    '{OP_MIDI_BYTE, 8'h3C, 4'd0, CHK_NONE,  NO_EVT},
    '{OP_MIDI_BYTE, 8'h40, 4'd0, CHK_NONE,  NO_EVT}
  };

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic       op;
  logic [7:0] midi_byte;
  logic [3:0] silent_voice;
  logic       out_valid;
  logic       out_ready;
  logic       action;
  logic [3:0] voice_index;
  logic [6:0] note_number;
  logic [6:0] key_velocity;

  midi_note_voice_allocator dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .midi_byte    (midi_byte),
    .silent_voice (silent_voice),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .action       (action),
    .voice_index  (voice_index),
    .note_number  (note_number),
    .key_velocity (key_velocity)
  );

  always #1 clk = ~clk;

  // Shadow of the parser and voice bank
  logic [7:0]        run_status;
  bit                pair_half;
  logic [6:0]        held_byte;
  logic [NOTE_W-1:0] slot_note [VOICE_COUNT];
  mode_t             slot_mode [VOICE_COUNT];

  voice_evt_t voice_events_due [$];
  int         mismatches;
  bit         quiet_phase;
  bit         rx_hold_req;

  function automatic bit track_voice_event(input logic o, input logic [7:0] b,
                                           input logic [3:0] v, output voice_evt_t e);
    int                pick;
    logic [NOTE_W-1:0] note;
    logic [6:0]        vel;
    e = NO_EVT;
    if (o == OP_SILENT) begin
      if (v < VOICE_COUNT) begin
        slot_note[v] = '0;
        slot_mode[v] = MODE_SILENT;
      end
      return 1'b0;
    end
    if (b == MIDI_CLOCK || b == ACTIVE_SENSE) return 1'b0;
    if (b[7]) begin
      run_status = b;
      pair_half  = 1'b0;
      return 1'b0;
    end
    if (!pair_half) begin
      held_byte = b[6:0];
      pair_half = 1'b1;
      return 1'b0;
    end
    pair_half = 1'b0;
    note      = held_byte;
    vel       = b[6:0];
    if (run_status[7:4] == CMD_NOTE_ON && vel != 0) begin
      if (note < NOTE_LOW || note > NOTE_HIGH) return 1'b0;
      pick = -1;
      for (int k = 0; k < VOICE_COUNT; k++)
        if (pick < 0 && slot_mode[k] == MODE_SILENT) pick = k;
      for (int k = 0; k < VOICE_COUNT; k++)
        if (pick < 0 && slot_mode[k] == MODE_RELEASING) pick = k;
      // every voice held: drop the note
      if (pick < 0) return 1'b0;
      slot_note[pick] = note;
      slot_mode[pick] = MODE_HELD;
      e = '{ACT_START, 4'(pick), note, vel};
      return 1'b1;
    end
    if (run_status[7:4] == CMD_NOTE_ON || run_status[7:4] == CMD_NOTE_OFF) begin
      for (int k = 0; k < VOICE_COUNT; k++) begin
        if (slot_mode[k] == MODE_HELD && slot_note[k] == note) begin
          slot_note[k] = '0;
          slot_mode[k] = MODE_RELEASING;
          e = '{ACT_RELEASE, 4'(k), note, 7'd0};
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  task automatic note_mismatch(input string why, input voice_evt_t want,
                               input voice_evt_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t mismatch (%s): expected act=%0d voice=%0d note=%0d vel=%0d, %s",
               $time, why, want.action, want.voice, want.note, want.vel,
               $sformatf("got act=%0d voice=%0d note=%0d vel=%0d",
                         got.action, got.voice, got.note, got.vel));
  endtask

  // Called at a rising edge; returns at the edge that takes the transaction.
  task automatic offer(input logic o, input logic [7:0] b, input logic [3:0] v,
                       input row_check_t chk, input voice_evt_t typed);
    int         gap;
    bit         hit;
    voice_evt_t e;
    gap = 0;
    if (!quiet_phase)
      while ($urandom_range(99) < 27) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    op           <= o;
    midi_byte    <= b;
    silent_voice <= v;
    do @(negedge clk); while (in_ready !== 1'b1);
    hit = track_voice_event(o, b, v, e);
    if (chk == CHK_EVENT)
      voice_events_due.push_back(typed);
    else if (chk == CHK_MODEL && hit)
      voice_events_due.push_back(e);
    @(posedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b);
    offer(OP_MIDI_BYTE, b, 4'($urandom_range(15)), CHK_MODEL, NO_EVT);
  endtask

  task automatic run_random(input int n);
    int                sent;
    int                r;
    logic [NOTE_W-1:0] note;
    logic [6:0]        vel;
    logic [3:0]        k;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(99);
      if (r < 55) begin
        // well-formed note message, sometimes with a fresh status byte
        if ($urandom_range(3) == 0) begin
          send_byte({($urandom_range(3) == 0) ? CMD_NOTE_OFF : CMD_NOTE_ON,
                     4'($urandom_range(15))});
          sent++;
        end
        k = 4'($urandom_range(VOICE_COUNT - 1));
        case ($urandom_range(9))
          0: note = 7'($urandom_range(127));
          1: note = $urandom_range(1) ? NOTE_LOW - 7'($urandom_range(1))
                                      : NOTE_HIGH + 7'($urandom_range(1));
          2, 3, 4: note = (slot_note[k] != 0) ? slot_note[k] : 7'(21 + $urandom_range(15));
          default: note = 7'(21 + $urandom_range(15));
        endcase
        vel = ($urandom_range(4) == 0) ? 7'd0 : 7'($urandom_range(127, 1));
        send_byte({1'b0, note});
        if ($urandom_range(9) == 0) begin
          send_byte($urandom_range(1) ? MIDI_CLOCK : ACTIVE_SENSE);
          sent++;
        end
        send_byte({1'b0, vel});
        sent += 2;
      end else if (r < 70) begin
        offer(OP_SILENT, 8'($urandom),
              ($urandom_range(4) == 0) ? 4'($urandom_range(15))
                                       : 4'($urandom_range(VOICE_COUNT - 1)),
              CHK_MODEL, NO_EVT);
        sent++;
      end else if (r < 78) begin
        send_byte($urandom_range(1) ? MIDI_CLOCK : ACTIVE_SENSE);
        sent++;
      end else if (r < 90) begin
        send_byte(8'($urandom));
        sent++;
      end else begin
        // other status bytes, system and real-time ones included
        send_byte(8'($urandom_range(255, 160)));
        sent++;
      end
    end
  endtask

  // Receiver: random back-pressure plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= quiet_phase || ($urandom_range(99) >= 27);
    end
  end

  voice_evt_t got_evt;
  voice_evt_t want_evt;

  always @(negedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready) begin
      got_evt = '{action, voice_index, note_number, key_velocity};
      if (voice_events_due.size() == 0) begin
        note_mismatch("unexpected transaction", NO_EVT, got_evt);
      end else begin
        want_evt = voice_events_due.pop_front();
        if (got_evt.action !== want_evt.action || got_evt.voice !== want_evt.voice ||
            got_evt.note !== want_evt.note || got_evt.vel !== want_evt.vel)
          note_mismatch("field", want_evt, got_evt);
      end
    end
  end

  initial begin
    #1000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int i;
    int guard;
    rst          = 1'b1;
    in_valid     = 1'b0;
    op           = OP_MIDI_BYTE;
    midi_byte    = '0;
    silent_voice = '0;
    mismatches   = 0;
    quiet_phase  = 1'b0;
    rx_hold_req  = 1'b0;
    run_status   = '0;
    pair_half    = 1'b0;
    held_byte    = '0;
    for (i = 0; i < VOICE_COUNT; i++) begin
      slot_note[i] = '0;
      slot_mode[i] = MODE_SILENT;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < SCRIPT_LEN; i++)
      offer(SCRIPT[i].op, SCRIPT[i].midi_byte, SCRIPT[i].silent_voice,
            SCRIPT[i].chk, SCRIPT[i].evt);

    // hold the receiver so the output register fills and the input stalls
    rx_hold_req = 1'b1;
    run_random(150);

    // pause the sender until every pending result is out
    in_valid <= 1'b0;
    do @(posedge clk); while (voice_events_due.size() != 0);

    quiet_phase = 1'b1;
    run_random(120);
    quiet_phase = 1'b0;
    run_random(180);
    in_valid <= 1'b0;

    guard = 0;
    while (voice_events_due.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (VOICE_COUNT + 4) @(posedge clk);
    while (voice_events_due.size() != 0)
      note_mismatch("missing transaction", voice_events_due.pop_front(), NO_EVT);

    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
